>>> rtl/core/ascii_integer_parser_top_assert.svh
// Assertion macros for the ASCII integer parser top level.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASCII_INTEGER_PARSER_TOP_ASSERT_SVH
`define ASCII_INTEGER_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/aip_pkg.sv
// Shared types, character codes and range helper for the ASCII integer parser.
// No dependencies; aip_step, the top level and the testbench import this package.
package aip_pkg;

  localparam int ACC_W  = 64;
  localparam int PROD_W = ACC_W + 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIGNED = 2'd1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef enum logic [5:0] {
    PH_START    = 6'b000001,
    PH_SIGN     = 6'b000010,
    PH_ZERO     = 6'b000100,
    PH_HEXFIRST = 6'b001000,
    PH_DEC      = 6'b010000,
    PH_HEX      = 6'b100000
  } phase_t;

  typedef struct packed {
    logic wide;
    logic sgn;
  } cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic             neg;
    logic [ACC_W-1:0] acc;
    logic             failed;
  } parse_st_t;

  localparam parse_st_t ST_CLEAR = '{phase: PH_START, neg: 1'b0, acc: '0, failed: 1'b0};

  // Largest magnitude allowed for the selected range and sign.
  function automatic logic [ACC_W-1:0] mag_limit(input cfg_t cfg, input logic neg);
    logic [ACC_W-1:0] half;
    logic [ACC_W-1:0] lim;
    half = cfg.wide ? {1'b1, {(ACC_W-1){1'b0}}} : {32'd0, 1'b1, 31'd0};
    if (cfg.sgn) begin
      lim = neg ? half : half - {{(ACC_W-1){1'b0}}, 1'b1};
    end else if (neg) begin
      lim = '0;
    end else begin
      lim = cfg.wide ? {ACC_W{1'b1}} : {32'd0, 32'hFFFF_FFFF};
    end
    return lim;
  endfunction

endpackage

>>> rtl/core/aip_chan_if.sv
// Valid/ready channel interfaces: byte input and parse result output.
// Standalone; no package dependency.
interface aip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface aip_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] parsed_value;
  logic        parse_ok;

  modport source (output valid, output parsed_value, output parse_ok, input ready);
  modport sink (input valid, input parsed_value, input parse_ok, output ready);
endinterface

>>> rtl/core/aip_step.sv
// One grammar step of the parser: next state and end-of-string result for one byte.
// Depends on aip_pkg.
module aip_step
  import aip_pkg::*;
(
  input  logic [7:0]        ch,
  input  parse_st_t         cur,
  input  cfg_t              cfg,
  output parse_st_t         st_nxt,
  output logic              term,
  output logic              res_ok,
  output logic [ACC_W-1:0]  res_val
);

  logic [ACC_W-1:0]  lim;
  logic              is_dec;
  logic              is_hex;
  logic [3:0]        hex_dig;
  logic [PROD_W-1:0] dec_prod;
  logic [PROD_W-1:0] hex_prod;
  logic              dec_fit;
  logic              hex_fit;

  assign lim    = mag_limit(cfg, cur.neg);
  assign is_dec = (ch >= CH_ZERO) && (ch <= CH_NINE);

  always_comb begin
    is_hex  = 1'b1;
    hex_dig = ch[3:0];
    if (is_dec) begin
      hex_dig = ch[3:0];
    end else if (((ch >= CH_UA) && (ch <= CH_UF)) || ((ch >= CH_LA) && (ch <= CH_LF))) begin
      hex_dig = 4'(ch[3:0] + 4'd9);
    end else begin
      is_hex = 1'b0;
    end
  end

  // acc*10 + digit and acc*16 + digit, compared in full width against the limit
  assign dec_prod = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0}
                  + {{(PROD_W-4){1'b0}}, ch[3:0]};
  assign hex_prod = {cur.acc, hex_dig};
  assign dec_fit  = dec_prod <= {4'd0, lim};
  assign hex_fit  = hex_prod <= {4'd0, lim};

  assign term = (ch == CH_NUL);

  always_comb begin
    st_nxt  = cur;
    res_ok  = 1'b0;
    res_val = '0;
    if (term) begin
      if (!cur.failed) begin
        if (cur.phase == PH_ZERO) begin
          res_ok = 1'b1;
        end else if ((cur.phase == PH_DEC) || (cur.phase == PH_HEX)) begin
          res_ok = cur.acc <= lim;
        end
      end
      if (res_ok) begin
        res_val = cur.neg ? ('0 - cur.acc) : cur.acc;
      end
      st_nxt = ST_CLEAR;
    end else if (!cur.failed) begin
      case (cur.phase)
        PH_START, PH_SIGN: begin
          if ((ch == CH_MINUS) && (cur.phase == PH_START) && cfg.sgn) begin
            st_nxt.neg   = 1'b1;
            st_nxt.phase = PH_SIGN;
          end else if (ch == CH_ZERO) begin
            st_nxt.phase = PH_ZERO;
          end else if ((ch >= CH_ONE) && (ch <= CH_NINE)) begin
            st_nxt.phase = PH_DEC;
            if (dec_fit) begin
              st_nxt.acc = dec_prod[ACC_W-1:0];
            end else begin
              st_nxt.failed = 1'b1;
            end
          end else begin
            st_nxt.failed = 1'b1;
          end
        end
        PH_ZERO: begin
          if (ch == CH_X) begin
            st_nxt.phase = PH_HEXFIRST;
          end else begin
            st_nxt.failed = 1'b1;
          end
        end
        PH_DEC: begin
          if (is_dec && dec_fit) begin
            st_nxt.acc = dec_prod[ACC_W-1:0];
          end else begin
            st_nxt.failed = 1'b1;
          end
        end
        PH_HEXFIRST, PH_HEX: begin
          if (is_hex) begin
            st_nxt.phase = PH_HEX;
            if (hex_fit) begin
              st_nxt.acc = hex_prod[ACC_W-1:0];
            end else begin
              st_nxt.failed = 1'b1;
            end
          end else begin
            st_nxt.failed = 1'b1;
          end
        end
        default: begin
          st_nxt.failed = 1'b1;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/ascii_integer_parser_top.sv
// ASCII integer parser top level: input byte register, grammar step, result register.
// A terminator byte waits in the input byte register until the result register is free.
// Throughput: one byte per cycle unless a terminator stalls; aip_step's loop sets it.
// Reset (rst_n low, synchronous): state to start of string, 64-bit signed mode.
// Depends on aip_pkg, aip_chan_if, aip_step and the assertion macro header.
`include "ascii_integer_parser_top_assert.svh"

module ascii_integer_parser_top
  import aip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  aip_in_if.sink                in_if,
  aip_out_if.source             out_if,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t             cfg_r;
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  parse_st_t        st_r;
  parse_st_t        st_nxt;
  logic             term;
  logic             res_ok;
  logic [ACC_W-1:0] res_val;
  logic             out_valid_r;
  logic             out_ok_r;
  logic [ACC_W-1:0] out_val_r;
  logic             out_free;
  logic             s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wide <= 1'b1;
      cfg_r.sgn  <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_WIDE:   cfg_r.wide <= cfg_wdata[0];
        CFG_IDX_SIGNED: cfg_r.sgn  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  aip_step u_step (
    .ch      (s1_byte_r),
    .cur     (st_r),
    .cfg     (cfg_r),
    .st_nxt  (st_nxt),
    .term    (term),
    .res_ok  (res_ok),
    .res_val (res_val)
  );

  // A terminator may only advance when the result register can take it
  assign out_free     = !out_valid_r || out_if.ready;
  assign s1_go        = s1_valid_r && (!term || out_free);
  assign in_if.ready  = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_byte_r <= in_if.char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
    end else if (s1_go) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && term) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && term) begin
      out_val_r <= res_val;
      out_ok_r  <= res_ok;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.parsed_value = out_val_r;
  assign out_if.parse_ok     = out_ok_r;

  `AIP_ASSERT_NOW(a_fail_zero, out_valid_r && !out_ok_r, out_val_r == '0, "failed parse with nonzero value")
  `AIP_ASSERT_NEXT(a_term_clear, s1_go && term, (st_r.phase == PH_START) && !st_r.neg && !st_r.failed && (st_r.acc == '0), "state not cleared after terminator")
  `AIP_ASSERT_NEXT(a_fail_hold, st_r.failed && !(s1_go && term), $stable(st_r.acc) && st_r.failed, "failed string changed its accumulator")
  `AIP_ASSERT_NOW(a_neg_phase, st_r.neg, st_r.phase != PH_START, "minus flag set at start of string")

endmodule

>>> test/testbench.sv
// Self-checking testbench for ascii_integer_parser_top: random byte strings in, parse results out.
// Predicts each result from its own parser model and compares field by field.
// Depends on aip_pkg and the aip_in_if / aip_out_if channel interfaces.
module testbench;
  import aip_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;
  localparam logic [4:0]           NOT_HEX         = 5'd16;
  localparam int                   SETTLE_CYCLES   = 6;
  localparam int                   PHASE_CHARS     = 200;

  typedef struct packed {
    logic [63:0] value;
    logic        ok;
  } parse_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  aip_in_if  in_ch ();
  aip_out_if out_ch ();

  ascii_integer_parser_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [7:0]    char_q[$];
  parse_result_t expected_results[$];
  int            chars_queued = 0;
  int            mismatches = 0;
  bit            no_idle = 1'b0;
  bit            char_taken = 1'b0;
  int            in_gap = 0;
  int            out_gap = 0;

  // Shadow of the parser: modes and the grammar state of the current string
  cfg_t         mode = '{wide: 1'b1, sgn: 1'b1};
  phase_t       parse_at = PH_START;
  logic         is_neg = 1'b0;
  logic [63:0]  magnitude = '0;
  logic         string_bad = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Largest magnitude the current modes accept for the given sign
  function automatic logic [63:0] range_top(input cfg_t m, input logic neg);
    logic [63:0] top;
    if (!m.sgn) begin
      top = neg ? 64'd0 : (m.wide ? {64{1'b1}} : 64'h0000_0000_FFFF_FFFF);
    end else begin
      top = m.wide ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h0000_0000_7FFF_FFFF;
      if (neg) top = top + 64'd1;
    end
    return top;
  endfunction

  function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
    if (ch >= CH_ZERO && ch <= CH_NINE) return 5'(ch - CH_ZERO);
    if (ch >= CH_UA && ch <= CH_UF) return 5'(ch - CH_UA + 8'd10);
    if (ch >= CH_LA && ch <= CH_LF) return 5'(ch - CH_LA + 8'd10);
    return NOT_HEX;
  endfunction

  // Shift one digit in; mark the string bad if the value would leave the range
  task automatic shift_digit(input logic [3:0] digit, input logic [4:0] radix);
    logic [67:0] grown;
    grown = magnitude * radix + digit;
    if (grown <= {4'd0, range_top(mode, is_neg)}) magnitude = grown[63:0];
    else string_bad = 1'b1;
  endtask

  task automatic advance_parser(input logic [7:0] ch);
    logic [4:0]    nib;
    logic          good;
    parse_result_t res;
    if (ch == CH_NUL) begin
      good = 1'b0;
      if (!string_bad) begin
        if (parse_at == PH_ZERO) good = 1'b1;
        else if (parse_at == PH_DEC || parse_at == PH_HEX)
          good = (magnitude <= range_top(mode, is_neg));
      end
      res.ok = good;
      res.value = good ? (is_neg ? 64'd0 - magnitude : magnitude) : 64'd0;
      expected_results.push_back(res);
      parse_at = PH_START;
      is_neg = 1'b0;
      magnitude = '0;
      string_bad = 1'b0;
    end else if (!string_bad) begin
      case (parse_at)
        PH_START, PH_SIGN: begin
          if (ch == CH_MINUS && parse_at == PH_START && mode.sgn) begin
            is_neg = 1'b1;
            parse_at = PH_SIGN;
          end else if (ch == CH_ZERO) begin
            parse_at = PH_ZERO;
          end else if (ch >= CH_ONE && ch <= CH_NINE) begin
            parse_at = PH_DEC;
            shift_digit(4'(ch - CH_ZERO), 5'd10);
          end else begin
            string_bad = 1'b1;
          end
        end
        PH_ZERO: begin
          if (ch == CH_X) parse_at = PH_HEXFIRST;
          else string_bad = 1'b1;
        end
        PH_DEC: begin
          if (ch >= CH_ZERO && ch <= CH_NINE) shift_digit(4'(ch - CH_ZERO), 5'd10);
          else string_bad = 1'b1;
        end
        PH_HEXFIRST, PH_HEX: begin
          nib = hex_nibble(ch);
          if (nib != NOT_HEX) begin
            parse_at = PH_HEX;
            shift_digit(nib[3:0], 5'd16);
          end else begin
            string_bad = 1'b1;
          end
        end
        default: string_bad = 1'b1;
      endcase
    end
  endtask

  // Input side: predict on every accepted item and retire it from the queue
  always @(posedge clk) begin
    char_taken = rst_n && in_ch.valid && in_ch.ready;
    if (char_taken) begin
      advance_parser(in_ch.char_byte);
      void'(char_q.pop_front());
    end
  end

  // Driver: hold a presented item until taken, otherwise idle in bursts or present the next
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !char_taken) begin
      // hold
    end else if (in_gap > 0) begin
      in_gap--;
      in_ch.valid <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      in_gap = $urandom_range(0, 6);
      in_ch.valid <= 1'b0;
    end else if (char_q.size() > 0) begin
      in_ch.valid <= 1'b1;
      in_ch.char_byte <= char_q[0];
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Result side: stall in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 6);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h ok=%b",
                                  out_ch.parsed_value, out_ch.parse_ok));
      end else begin
        want = expected_results.pop_front();
        if (out_ch.parsed_value !== want.value)
          report_mismatch($sformatf("parsed_value %h, expected %h",
                                    out_ch.parsed_value, want.value));
        if (out_ch.parse_ok !== want.ok)
          report_mismatch($sformatf("parse_ok %b, expected %b", out_ch.parse_ok, want.ok));
      end
    end
  end

  task automatic put_char(input logic [7:0] ch);
    char_q.push_back(ch);
    chars_queued++;
  endtask

  task automatic queue_text(input string txt, input bit terminate = 1'b1);
    for (int i = 0; i < txt.len(); i++) put_char(txt[i]);
    if (terminate) put_char(CH_NUL);
  endtask

  // Drain all queued items and results, then let the pipeline empty
  task automatic wait_idle();
    while (char_q.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == CFG_IDX_WIDE) mode.wide = val;
    else if (idx == CFG_IDX_SIGNED) mode.sgn = val;
  endtask

  task automatic apply_modes(input logic wide, input logic sgn);
    write_reg(CFG_IDX_WIDE, wide);
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B, 1'($urandom));
    write_reg(CFG_IDX_SIGNED, sgn);
  endtask

  function automatic logic [63:0] pick_magnitude();
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 1000));
      1: return 64'h0000_0000_7FFF_FFFE + 64'($urandom_range(0, 3));
      2: return 64'h0000_0000_FFFF_FFFE + 64'($urandom_range(0, 2));
      3: return 64'h7FFF_FFFF_FFFF_FFFE + 64'($urandom_range(0, 3));
      4: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 2));
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  // Mostly well-formed numbers near the range edges; some noise and broken forms
  task automatic queue_random_string();
    int          kind;
    int          lead;
    logic [63:0] mag;
    string       txt;
    string       digits;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(0, 6)) put_char(8'($urandom_range(1, 255)));
      put_char(CH_NUL);
      return;
    end
    mag = pick_magnitude();
    txt = ($urandom_range(0, 2) == 0) ? "-" : "";
    if ($urandom_range(0, 1)) begin
      digits = $sformatf("%0h", mag);
      for (int i = 0; i < digits.len(); i++)
        if (digits[i] >= CH_LA && $urandom_range(0, 1)) digits.putc(i, digits[i] - 8'h20);
      lead = $urandom_range(0, 3);
      txt = {txt, "0x"};
      repeat (lead) txt = {txt, "0"};
      txt = {txt, digits};
    end else begin
      txt = {txt, $sformatf("%0d", mag)};
    end
    if (kind < 18) begin
      // append one more digit to push edge values past the range
      txt = {txt, "0"};
      txt.putc(txt.len() - 1, CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (kind < 30) begin
      case ($urandom_range(0, 2))
        0: txt.putc($urandom_range(0, txt.len() - 1), 8'($urandom_range(1, 255)));
        1: txt = {"0", txt};
        default: txt = {"-", txt};
      endcase
    end
    queue_text(txt);
  endtask

  initial begin
    logic wide;
    logic sgn;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_IDX_WIDE;
    cfg_wdata = 1'b0;
    clk = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.char_byte = CH_NUL;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset modes: 64-bit signed
    queue_text("");
    queue_text("-");
    queue_text("0x");
    queue_text("-0");
    queue_text("-0x000");
    queue_text("0");
    queue_text("00");
    queue_text("0X1");
    queue_text("9223372036854775807");
    queue_text("-9223372036854775808");
    queue_text("9223372036854775808");
    queue_text("0x7fffFFFFffffffff");
    queue_text("-0x8000000000000001");
    queue_text("12a9");
    put_char(8'hFF);
    put_char(CH_NUL);
    wait_idle();
    apply_modes(1'b1, 1'b0);
    queue_text("18446744073709551615");
    queue_text("18446744073709551616");
    queue_text("0xFFFFFFFFFFFFFFFF");
    queue_text("-5");
    wait_idle();
    apply_modes(1'b0, 1'b1);
    queue_text("2147483647");
    queue_text("-2147483648");
    queue_text("2147483648");
    queue_text("-0x80000000");
    wait_idle();
    apply_modes(1'b0, 1'b0);
    queue_text("4294967295");
    queue_text("4294967296");
    queue_text("0xffffffff");
    wait_idle();

    // Mode changes in the middle of a string
    apply_modes(1'b1, 1'b1);
    queue_text("5000000000", 1'b0);
    wait_idle();
    apply_modes(1'b0, 1'b1);
    queue_text("");
    wait_idle();
    apply_modes(1'b1, 1'b1);
    queue_text("-", 1'b0);
    wait_idle();
    apply_modes(1'b1, 1'b0);
    queue_text("0x0");
    wait_idle();
    apply_modes(1'b1, 1'b1);
    queue_text("-", 1'b0);
    wait_idle();
    apply_modes(1'b1, 1'b0);
    queue_text("1");
    wait_idle();

    for (int phase_no = 0; phase_no < 8; phase_no++) begin
      if (phase_no < 4) begin
        wide = phase_no[0];
        sgn = phase_no[1];
      end else begin
        wide = 1'($urandom);
        sgn = 1'($urandom);
      end
      apply_modes(wide, sgn);
      if (phase_no == 7) no_idle = 1'b1;
      chars_queued = 0;
      while (chars_queued < PHASE_CHARS) queue_random_string();
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/aip_pkg.sv
rtl/core/aip_chan_if.sv
rtl/core/aip_step.sv
rtl/core/ascii_integer_parser_top.sv
test/testbench.sv
